/* rtl/core/bcu_pkg.sv */
`timescale 1ns / 1ps

package bcu_pkg;

  typedef enum logic [1:0] {
    KIND_EXEC     = 2'd0,
    KIND_LOAD_CTR = 2'd1,
    KIND_LOAD_LR  = 2'd2,
    KIND_LOAD_CR  = 2'd3
  } kind_e;

  localparam logic [5:0] OP_CMPI = 6'd11;
  localparam logic [5:0] OP_BC   = 6'd16;
  localparam logic [5:0] OP_XL   = 6'd19;
  localparam logic [5:0] OP_RLWI = 6'd21;

  localparam logic [9:0] XO_BCLR = 10'd16;

  localparam logic [31:0] ADDR_WORD_MASK = 32'hffff_fffc;
  localparam logic [31:0] ADDR_STEP      = 32'd4;

  // condition field codes, before the SO bit is appended
  localparam logic [2:0] CODE_LT = 3'b100;
  localparam logic [2:0] CODE_GT = 3'b010;
  localparam logic [2:0] CODE_EQ = 3'b001;

  typedef struct packed {
    logic        taken;
    logic [31:0] ctr_next;
  } branch_t;

  function automatic logic [3:0] field_code(input logic lt, input logic gt, input logic so);
    logic [2:0] c;
    if (lt) begin
      c = CODE_LT;
    end else if (gt) begin
      c = CODE_GT;
    end else begin
      c = CODE_EQ;
    end
    return {c, so};
  endfunction

  function automatic logic [31:0] write_field(input logic [31:0] cr, input logic [2:0] field,
                                              input logic [3:0] code);
    logic [4:0] sh;
    sh = 5'd28 - {field, 2'b00};
    return (cr & ~(32'h0000_000f << sh)) | ({28'd0, code} << sh);
  endfunction

endpackage

/* rtl/core/bcu_branch.sv */
`timescale 1ns / 1ps

module bcu_branch (
  input  logic [31:0]      insn_i,
  input  logic [31:0]      cr_i,
  input  logic [31:0]      ctr_i,
  output bcu_pkg::branch_t br_o
);
  import bcu_pkg::*;

  logic [4:0] bo;
  logic [4:0] bi;
  logic       crbit;
  logic       ctr_ok;
  logic       cond_ok;

  assign bo = insn_i[25:21];
  assign bi = insn_i[20:16];
  // bit 0 of the CR is the msb
  assign crbit = cr_i[5'd31 - bi];

  always_comb begin
    br_o.ctr_next = bo[2] ? ctr_i : ctr_i - 32'd1;
    ctr_ok        = bo[2] || ((br_o.ctr_next != 32'd0) ^ bo[1]);
    cond_ok       = bo[4] || (crbit == bo[3]);
    br_o.taken    = ctr_ok && cond_ok;
  end

endmodule

/* rtl/core/bcu_rotate.sv */
`timescale 1ns / 1ps

module bcu_rotate (
  input  logic [31:0] src_i,
  input  logic [4:0]  sh_i,
  input  logic [4:0]  mb_i,
  input  logic [4:0]  me_i,
  output logic [31:0] value_o
);
  import bcu_pkg::*;

  logic [63:0] rot_wide;
  logic [31:0] from_mb;
  logic [31:0] to_me;
  logic [31:0] mask;

  always_comb begin
    rot_wide = {src_i, src_i} << sh_i;
    from_mb  = 32'hffff_ffff >> mb_i;
    to_me    = ~((32'hffff_ffff >> me_i) >> 1);
    // mask wraps round when mb > me
    mask     = (mb_i <= me_i) ? (from_mb & to_me) : (from_mb | to_me);
    value_o  = rot_wide[63:32] & mask;
  end

endmodule

/* rtl/core/branch_condition_unit.sv */
`timescale 1ns / 1ps
// An item in the input register moves to the result register when the output is free.
// Throughput: one item per cycle while results are not stalled; CR, CTR and LR are read
// and updated in the execute stage as an item moves from the input register to the
// result register.
// Reset: asynchronous, active low; clears CR, CTR, LR and both valid flags.
module branch_condition_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] instruction_i,
  input  logic [31:0] current_address_i,
  input  logic [31:0] source_value_i,
  input  logic        summary_overflow_i,
  input  logic [31:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_address_o,
  output logic        reg_write_enable_o,
  output logic [4:0]  reg_write_index_o,
  output logic [31:0] reg_write_value_o,
  output logic [31:0] condition_value_o,
  output logic [31:0] count_value_o,
  output logic [31:0] link_value_o,
  output logic        unsupported_o
);
  import bcu_pkg::*;

  logic        s1_valid_q;
  logic [1:0]  s1_kind_q;
  logic [31:0] s1_insn_q;
  logic [31:0] s1_cia_q;
  logic [31:0] s1_src_q;
  logic        s1_so_q;
  logic [31:0] s1_load_q;

  logic [31:0] cr_q, cr_d;
  logic [31:0] ctr_q, ctr_d;
  logic [31:0] lr_q, lr_d;

  logic        out_valid_q;
  logic [31:0] next_q, next_d;
  logic        wen_q, wen_d;
  logic [4:0]  widx_q, widx_d;
  logic [31:0] wval_q, wval_d;
  logic        unsup_q, unsup_d;

  logic        advance;
  logic        in_take;

  branch_t     br;
  logic [31:0] rot_value;
  logic [5:0]  opcode;
  logic [31:0] cia_plus4;
  logic [31:0] disp;
  logic [31:0] imm;
  logic        cmp_lt;
  logic        cmp_gt;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  bcu_branch u_branch (
    .insn_i (s1_insn_q),
    .cr_i   (cr_q),
    .ctr_i  (ctr_q),
    .br_o   (br)
  );

  bcu_rotate u_rotate (
    .src_i   (s1_src_q),
    .sh_i    (s1_insn_q[15:11]),
    .mb_i    (s1_insn_q[10:6]),
    .me_i    (s1_insn_q[5:1]),
    .value_o (rot_value)
  );

  assign opcode    = s1_insn_q[31:26];
  assign cia_plus4 = s1_cia_q + ADDR_STEP;
  assign disp      = {{16{s1_insn_q[15]}}, s1_insn_q[15:2], 2'b00};
  assign imm       = {{16{s1_insn_q[15]}}, s1_insn_q[15:0]};
  assign cmp_lt    = $signed(s1_src_q) < $signed(imm);
  assign cmp_gt    = $signed(s1_src_q) > $signed(imm);

  always_comb begin
    cr_d    = cr_q;
    ctr_d   = ctr_q;
    lr_d    = lr_q;
    next_d  = 32'd0;
    wen_d   = 1'b0;
    widx_d  = 5'd0;
    wval_d  = 32'd0;
    unsup_d = 1'b0;
    unique case (kind_e'(s1_kind_q))
      KIND_LOAD_CTR: ctr_d = s1_load_q;
      KIND_LOAD_LR:  lr_d  = s1_load_q;
      KIND_LOAD_CR:  cr_d  = s1_load_q;
      KIND_EXEC: begin
        priority if (opcode == OP_BC) begin
          ctr_d  = br.ctr_next;
          next_d = br.taken ? (s1_insn_q[1] ? disp : s1_cia_q + disp) : cia_plus4;
          if (s1_insn_q[0]) begin
            lr_d = cia_plus4;
          end
        end else if (opcode == OP_XL && s1_insn_q[10:1] == XO_BCLR) begin
          // target uses LR before the link update
          ctr_d  = br.ctr_next;
          next_d = br.taken ? (lr_q & ADDR_WORD_MASK) : cia_plus4;
          if (s1_insn_q[0]) begin
            lr_d = cia_plus4;
          end
        end else if (opcode == OP_CMPI) begin
          cr_d   = write_field(cr_q, s1_insn_q[25:23], field_code(cmp_lt, cmp_gt, s1_so_q));
          next_d = cia_plus4;
        end else if (opcode == OP_RLWI) begin
          wen_d  = 1'b1;
          widx_d = s1_insn_q[20:16];
          wval_d = rot_value;
          if (s1_insn_q[0]) begin
            cr_d = write_field(cr_q, 3'd0,
                               field_code(rot_value[31], !rot_value[31] && rot_value != 32'd0,
                                          s1_so_q));
          end
          next_d = cia_plus4;
        end else begin
          unsup_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cr_q        <= 32'd0;
      ctr_q       <= 32'd0;
      lr_q        <= 32'd0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cr_q        <= cr_d;
        ctr_q       <= ctr_d;
        lr_q        <= lr_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= kind_i;
      s1_insn_q <= instruction_i;
      s1_cia_q  <= current_address_i;
      s1_src_q  <= source_value_i;
      s1_so_q   <= summary_overflow_i;
      s1_load_q <= load_value_i;
    end
    if (advance) begin
      next_q  <= next_d;
      wen_q   <= wen_d;
      widx_q  <= widx_d;
      wval_q  <= wval_d;
      unsup_q <= unsup_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign next_address_o     = next_q;
  assign reg_write_enable_o = wen_q;
  assign reg_write_index_o  = widx_q;
  assign reg_write_value_o  = wval_q;
  assign condition_value_o  = cr_q;
  assign count_value_o      = ctr_q;
  assign link_value_o       = lr_q;
  assign unsupported_o      = unsup_q;

endmodule

/* rtl/core/bcu_checker.sv */
`timescale 1ns / 1ps

module bcu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] next_address_o,
  input logic        reg_write_enable_o,
  input logic [4:0]  reg_write_index_o,
  input logic [31:0] reg_write_value_o,
  input logic [31:0] condition_value_o,
  input logic [31:0] count_value_o,
  input logic [31:0] link_value_o,
  input logic        unsupported_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_address_o)
      && $stable(condition_value_o) && $stable(count_value_o) && $stable(link_value_o))
    else $error("stalled result item changed");

  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> next_address_o == 32'd0 && !reg_write_enable_o
      && reg_write_value_o == 32'd0)
    else $error("unsupported item produced a result");

  a_widx_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_write_enable_o |-> reg_write_index_o == 5'd0
      && reg_write_value_o == 32'd0)
    else $error("register write fields set without write enable");

  // with the output side free, the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind branch_condition_unit bcu_checker u_bcu_checker (.*);

/* bench/branch_condition_unit_tb.sv */
`timescale 1ns / 1ps

module branch_condition_unit_tb;
  import bcu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 150;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] insn;
    logic [31:0] cia;
    logic [31:0] src;
    logic        so;
    logic [31:0] load;
  } issue_t;

  typedef struct packed {
    logic [31:0] next;
    logic        wen;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] cr;
    logic [31:0] ctr;
    logic [31:0] lr;
    logic        unsup;
  } retire_t;

  // Tracks CR/CTR/LR as the block should see them and queues the retire
  // values each accepted item must produce.
  class branch_unit_tracker;
    logic [31:0] cr;
    logic [31:0] ctr;
    logic [31:0] lr;
    retire_t     expected_q[$];
    int unsigned errors;

    function new();
      cr = '0;
      ctr = '0;
      lr = '0;
      errors = 0;
    endfunction

    function void put_field(logic [2:0] f, logic lt, logic gt, logic so);
      logic [3:0] code;
      if (lt) begin
        code = {CODE_LT, so};
      end else if (gt) begin
        code = {CODE_GT, so};
      end else begin
        code = {CODE_EQ, so};
      end
      cr[(7 - int'(f)) * 4 +: 4] = code;
    endfunction

    // BO/BI test; decrements CTR first when BO[2] is clear
    function logic branch_resolve(logic [31:0] insn);
      logic [4:0] bo;
      logic [4:0] bi;
      logic       ctr_ok;
      logic       cond_ok;
      bo = insn[25:21];
      bi = insn[20:16];
      if (!bo[2]) ctr = ctr - 32'd1;
      ctr_ok  = bo[2] | ((ctr != 32'd0) ^ bo[1]);
      cond_ok = bo[4] | (cr[31 - int'(bi)] == bo[3]);
      return ctr_ok & cond_ok;
    endfunction

    function void note_issue(issue_t it);
      retire_t           r;
      logic [5:0]        opc;
      logic [31:0]       disp;
      logic [31:0]       tgt;
      logic signed [31:0] a;
      logic signed [31:0] s;
      logic [4:0]        sh;
      logic [4:0]        mb;
      logic [4:0]        me;
      logic [63:0]       dbl;
      logic [31:0]       from_mb;
      logic [31:0]       to_me;
      logic [31:0]       msk;
      r = '0;
      opc = it.insn[31:26];
      case (it.kind)
        KIND_LOAD_CTR: ctr = it.load;
        KIND_LOAD_LR:  lr = it.load;
        KIND_LOAD_CR:  cr = it.load;
        default: begin
          if (opc == OP_BC) begin
            disp = {{16{it.insn[15]}}, it.insn[15:2], 2'b00};
            if (branch_resolve(it.insn)) begin
              r.next = it.insn[1] ? disp : it.cia + disp;
            end else begin
              r.next = it.cia + ADDR_STEP;
            end
            if (it.insn[0]) lr = it.cia + ADDR_STEP;
          end else if (opc == OP_XL && it.insn[10:1] == XO_BCLR) begin
            tgt = lr & ADDR_WORD_MASK;  // old LR, before any link update
            if (branch_resolve(it.insn)) begin
              r.next = tgt;
            end else begin
              r.next = it.cia + ADDR_STEP;
            end
            if (it.insn[0]) lr = it.cia + ADDR_STEP;
          end else if (opc == OP_CMPI) begin
            a = it.src;
            s = {{16{it.insn[15]}}, it.insn[15:0]};
            put_field(it.insn[25:23], a < s, a > s, it.so);
            r.next = it.cia + ADDR_STEP;
          end else if (opc == OP_RLWI) begin
            sh = it.insn[15:11];
            mb = it.insn[10:6];
            me = it.insn[5:1];
            dbl = {it.src, it.src} << sh;
            from_mb = 32'hffff_ffff >> mb;
            to_me = ~((32'hffff_ffff >> me) >> 1);
            msk = (mb <= me) ? (from_mb & to_me) : (from_mb | to_me);
            r.wval = dbl[63:32] & msk;
            r.wen = 1'b1;
            r.widx = it.insn[20:16];
            if (it.insn[0]) begin
              put_field(3'd0, r.wval[31], !r.wval[31] && r.wval != 32'd0, it.so);
            end
            r.next = it.cia + ADDR_STEP;
          end else begin
            r.unsup = 1'b1;
          end
        end
      endcase
      r.cr = cr;
      r.ctr = ctr;
      r.lr = lr;
      expected_q = {expected_q, r};
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_retire(retire_t got);
      retire_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending, next_address %h", $time, got.next);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare("next_address", exp.next, got.next);
      compare("reg_write_enable", 32'(exp.wen), 32'(got.wen));
      compare("reg_write_index", 32'(exp.widx), 32'(got.widx));
      compare("reg_write_value", exp.wval, got.wval);
      compare("condition_value", exp.cr, got.cr);
      compare("count_value", exp.ctr, got.ctr);
      compare("link_value", exp.lr, got.lr);
      compare("unsupported", 32'(exp.unsup), 32'(got.unsup));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [31:0] instruction_i;
  logic [31:0] current_address_i;
  logic [31:0] source_value_i;
  logic        summary_overflow_i;
  logic [31:0] load_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] next_address_o;
  logic        reg_write_enable_o;
  logic [4:0]  reg_write_index_o;
  logic [31:0] reg_write_value_o;
  logic [31:0] condition_value_o;
  logic [31:0] count_value_o;
  logic [31:0] link_value_o;
  logic        unsupported_o;

  branch_unit_tracker tracker = new();

  logic        burst = 1'b0;
  logic        long_hold_req = 1'b0;
  int unsigned pressure_left = 0;

  branch_condition_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .instruction_i      (instruction_i),
    .current_address_i  (current_address_i),
    .source_value_i     (source_value_i),
    .summary_overflow_i (summary_overflow_i),
    .load_value_i       (load_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .next_address_o     (next_address_o),
    .reg_write_enable_o (reg_write_enable_o),
    .reg_write_index_o  (reg_write_index_o),
    .reg_write_value_o  (reg_write_value_o),
    .condition_value_o  (condition_value_o),
    .count_value_o      (count_value_o),
    .link_value_o       (link_value_o),
    .unsupported_o      (unsupported_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic issue_t mk(kind_e kind, logic [31:0] insn, logic [31:0] cia,
                                logic [31:0] src, logic so, logic [31:0] load);
    issue_t it;
    it.kind = kind;
    it.insn = insn;
    it.cia = cia;
    it.src = src;
    it.so = so;
    it.load = load;
    return it;
  endfunction

  function automatic logic [31:0] enc_bc(logic [4:0] bo, logic [4:0] bi, logic [13:0] bd,
                                         logic aa, logic lk);
    return {OP_BC, bo, bi, bd, aa, lk};
  endfunction

  function automatic logic [31:0] enc_bclr(logic [4:0] bo, logic [4:0] bi, logic lk);
    return {OP_XL, bo, bi, 5'd0, XO_BCLR, lk};
  endfunction

  function automatic logic [31:0] enc_cmpi(logic [2:0] crf, logic l, logic [4:0] ra,
                                           logic [15:0] imm);
    return {OP_CMPI, crf, 1'b0, l, ra, imm};
  endfunction

  function automatic logic [31:0] enc_rlwi(logic [4:0] rs, logic [4:0] ra, logic [4:0] sh,
                                           logic [4:0] mb, logic [4:0] me, logic rc);
    return {OP_RLWI, rs, ra, sh, mb, me, rc};
  endfunction

  function automatic issue_t random_issue();
    issue_t      it;
    int unsigned pick;
    logic [5:0]  op;
    logic [9:0]  xo;
    logic [31:0] imm;
    it.kind = KIND_EXEC;
    it.insn = $urandom;
    it.cia = $urandom;
    it.src = $urandom;
    it.so = 1'($urandom_range(0, 1));
    it.load = $urandom;
    if ($urandom_range(0, 15) == 0) it.cia = ADDR_WORD_MASK;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.kind = kind_e'(2'($urandom_range(1, 3)));
      // small CTR values so decrements reach zero
      if (it.kind == KIND_LOAD_CTR && $urandom_range(0, 3) != 0) it.load = $urandom_range(0, 3);
    end else if (pick < 40) begin
      it.insn[31:26] = OP_BC;
    end else if (pick < 55) begin
      it.insn[31:26] = OP_XL;
      it.insn[10:1] = XO_BCLR;
    end else if (pick < 72) begin
      it.insn[31:26] = OP_CMPI;
      imm = {{16{it.insn[15]}}, it.insn[15:0]};
      case ($urandom_range(0, 3))
        0: it.src = imm;
        1: it.src = imm + 32'd1;
        2: it.src = imm - 32'd1;
        default: ;
      endcase
    end else if (pick < 92) begin
      it.insn[31:26] = OP_RLWI;
      if ($urandom_range(0, 7) == 0) it.src = '0;
    end else if (pick < 96) begin
      it.insn[31:26] = OP_XL;
      do xo = 10'($urandom); while (xo == XO_BCLR);
      it.insn[10:1] = xo;
    end else begin
      do op = 6'($urandom); while (op == OP_CMPI || op == OP_BC || op == OP_XL || op == OP_RLWI);
      it.insn[31:26] = op;
    end
    return it;
  endfunction

  // idle gap, then hold the item until the block takes it
  task automatic issue(issue_t it);
    int unsigned gap;
    gap = (burst || pressure_left > 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    instruction_i <= it.insn;
    current_address_i <= it.cia;
    source_value_i <= it.src;
    summary_overflow_i <= it.so;
    load_value_i <= it.load;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_issue(it);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i <= KIND_EXEC;
    instruction_i <= '0;
    current_address_i <= '0;
    source_value_i <= '0;
    summary_overflow_i <= 1'b0;
    load_value_i <= '0;
    out_stall_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(mk(KIND_LOAD_CTR, '0, '0, '0, 1'b0, 32'hffff_ffff));
    issue(mk(KIND_LOAD_CR, '1, '0, '0, 1'b1, 32'ha5a5_a5a5));
    // always taken, largest forward displacement, link wraps to zero
    issue(mk(KIND_EXEC, enc_bc(5'b10100, 5'd0, 14'h1fff, 1'b0, 1'b1), 32'hffff_fffc,
             '0, 1'b0, '0));
    // absolute, most negative displacement
    issue(mk(KIND_EXEC, enc_bc(5'b10100, 5'd31, 14'h2000, 1'b1, 1'b0), 32'h0000_1000,
             '0, 1'b0, '0));
    issue(mk(KIND_LOAD_LR, '0, '0, '0, 1'b0, 32'hffff_ffff));
    issue(mk(KIND_EXEC, enc_bclr(5'b10100, 5'd0, 1'b0), 32'h0000_2000, '0, 1'b0, '0));
    // decrement, branch on CTR nonzero and CR bit clear
    issue(mk(KIND_EXEC, enc_bc(5'b00000, 5'd31, 14'h0010, 1'b0, 1'b0), 32'h0000_3000,
             '0, 1'b0, '0));
    issue(mk(KIND_LOAD_CTR, '0, '0, '0, 1'b0, 32'd1));
    // decrement to zero, branch on CTR zero and CR bit clear
    issue(mk(KIND_EXEC, enc_bc(5'b00010, 5'd1, 14'h3fff, 1'b0, 1'b1), 32'h0000_4000,
             '0, 1'b0, '0));
    issue(mk(KIND_EXEC, enc_bc(5'b01100, 5'd0, 14'h0004, 1'b0, 1'b0), 32'h0000_5000,
             '0, 1'b0, '0));
    // link update with branch to the old LR
    issue(mk(KIND_EXEC, enc_bclr(5'b10100, 5'd2, 1'b1), 32'h8000_0000, '0, 1'b0, '0));
    issue(mk(KIND_EXEC, enc_bclr(5'b00100, 5'd0, 1'b0), 32'h0000_6000, '0, 1'b0, '0));
    issue(mk(KIND_EXEC, enc_cmpi(3'd0, 1'b0, 5'd1, 16'h7fff), 32'h0000_7000,
             32'h8000_0000, 1'b1, '0));
    issue(mk(KIND_EXEC, enc_cmpi(3'd7, 1'b0, 5'd31, 16'h8000), 32'h0000_7004,
             32'h7fff_ffff, 1'b0, '0));
    // L bit set: still a 32-bit compare; equal
    issue(mk(KIND_EXEC, enc_cmpi(3'd3, 1'b1, 5'd2, 16'hffff), 32'h0000_7008,
             32'hffff_ffff, 1'b1, '0));
    issue(mk(KIND_EXEC, enc_rlwi(5'd3, 5'd0, 5'd0, 5'd0, 5'd31, 1'b0), 32'h0000_8000,
             32'hdead_beef, 1'b0, '0));
    // mask wraps round when mb is past me
    issue(mk(KIND_EXEC, enc_rlwi(5'd4, 5'd31, 5'd31, 5'd31, 5'd0, 1'b1), 32'h0000_8004,
             32'h8000_0001, 1'b1, '0));
    issue(mk(KIND_EXEC, enc_rlwi(5'd5, 5'd7, 5'd9, 5'd4, 5'd20, 1'b1), 32'h0000_8008,
             32'h0000_0000, 1'b0, '0));
    issue(mk(KIND_EXEC, enc_rlwi(5'd6, 5'd8, 5'd4, 5'd1, 5'd31, 1'b1), 32'h0000_800c,
             32'hffff_ffff, 1'b1, '0));
    // XL form other than bclr, then plain unknown opcodes
    issue(mk(KIND_EXEC, {OP_XL, 5'b10100, 5'd0, 5'd0, 10'd528, 1'b1}, 32'h0000_9000,
             '0, 1'b0, '0));
    issue(mk(KIND_EXEC, 32'h0000_0000, 32'h0000_9004, '1, 1'b1, '1));
    issue(mk(KIND_EXEC, 32'hffff_ffff, 32'hffff_ffff, '1, 1'b1, '1));
    issue(mk(KIND_LOAD_CR, '0, '1, '1, 1'b0, 32'h0000_0000));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == 300 || i == 900) begin
        long_hold_req = 1'b1;
        pressure_left = 60;
      end
      issue(random_issue());
      if (pressure_left > 0) pressure_left--;
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("branch_condition_unit_tb: PASS");
    end else begin
      $display("branch_condition_unit_tb: FAIL");
    end
    $finish;
  end

  // result side: random stall before each item outside bursts, one long hold per request
  initial begin
    int unsigned hold;
    retire_t     got;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (burst) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.next = next_address_o;
      got.wen = reg_write_enable_o;
      got.widx = reg_write_index_o;
      got.wval = reg_write_value_o;
      got.cr = condition_value_o;
      got.ctr = count_value_o;
      got.lr = link_value_o;
      got.unsup = unsupported_o;
      tracker.check_retire(got);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout", $time);
    $display("branch_condition_unit_tb: FAIL");
    $finish;
  end

endmodule
